// File: rtl/bdq_pkg.sv
`default_nettype none

package bdq_pkg;

  // Capacity of the store and the widths that follow from it.
  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int AW     = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Operation codes carried in the mode field of a command.
  localparam logic [2:0] MODE_INSERT_FRONT = 3'd0;
  localparam logic [2:0] MODE_INSERT_BACK  = 3'd1;
  localparam logic [2:0] MODE_REMOVE_FRONT = 3'd2;
  localparam logic [2:0] MODE_SEARCH       = 3'd3;
  localparam logic [2:0] MODE_CLEAR        = 3'd4;

  typedef struct packed {
    logic [2:0]               mode;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic                     found;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] back_value;
    logic [CNT_W-1:0]         count;
    logic                     refused;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REFILL,
    ST_SEARCH
  } state_t;

  // Slot arithmetic on the ring: both operands stay below DEPTH, so one
  // conditional subtract brings the sum back into range.
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a,
                                              input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(a) + (CNT_W+1)'(b);
    if (s >= (CNT_W+1)'(DEPTH)) begin
      s = s - (CNT_W+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/bdq_ram.sv
`default_nettype none

module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/bounded_deque_with_search.sv
// Inserts, clear, unused codes, a search of an empty store and a remove that leaves
// the store empty give their result in the cycle after start.
// Removing from a store with two or more entries goes through ST_REFILL to read the new front.
// A search makes one memory read per entry, ending early on a match.
// Throughput: one item at a time; busy stays high until the item's result is issued.
// The receiver cannot stall: done is a one-cycle strobe. Synchronous active-high reset empties.
`default_nettype none

module bounded_deque_with_search
  import bdq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire cmd_t cmd,
  output logic      busy,
  output logic      done,
  output result_t   result
);

  // The entries live in a single-port-write, single-port-read memory. The
  // front and back values are also kept in registers so that inserts can
  // report them without a read; only a remove needs to fetch the new front.
  state_t                   state, state_next;
  logic [AW-1:0]            head, head_next;
  logic [CNT_W-1:0]         occ, occ_next;
  logic [DATA_W-1:0]        front, front_next;
  logic [DATA_W-1:0]        back, back_next;
  logic [AW-1:0]            idx, idx_next;
  logic [DATA_W-1:0]        key, key_next;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic                     ram_re;
  logic [AW-1:0]            ram_raddr;
  logic [DATA_W-1:0]        ram_rdata;

  logic                     emit;
  logic                     res_found;
  logic                     res_refused;
  logic                     full;

  bdq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(cmd.value),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign full = (occ == CNT_W'(DEPTH));
  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head  <= '0;
      occ   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      occ   <= occ_next;
      done  <= emit;
    end
  end

  // Payload registers need no reset: they are only read when occupied or
  // when done marks them valid.
  always_ff @(posedge clk) begin
    front <= front_next;
    back  <= back_next;
    idx   <= idx_next;
    key   <= key_next;
    if (emit) begin
      result.found       <= res_found;
      result.front_value <= (occ_next == '0) ? '0 : front_next;
      result.back_value  <= (occ_next == '0) ? '0 : back_next;
      result.count       <= occ_next;
      result.refused     <= res_refused;
    end
  end

  always_comb begin
    state_next  = state;
    head_next   = head;
    occ_next    = occ;
    front_next  = front;
    back_next   = back;
    idx_next    = idx;
    key_next    = key;
    ram_we      = 1'b0;
    ram_waddr   = head;
    ram_re      = 1'b0;
    ram_raddr   = head;
    emit        = 1'b0;
    res_found   = 1'b0;
    res_refused = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          key_next = cmd.value;
          unique case (cmd.mode)
            MODE_INSERT_FRONT: begin
              emit = 1'b1;
              if (full) begin
                res_refused = 1'b1;
              end else begin
                head_next  = ring_add(head, CNT_W'(DEPTH - 1));
                ram_we     = 1'b1;
                ram_waddr  = head_next;
                front_next = cmd.value;
                if (occ == '0) begin
                  back_next = cmd.value;
                end
                occ_next = occ + CNT_W'(1);
              end
            end
            MODE_INSERT_BACK: begin
              emit = 1'b1;
              if (full) begin
                res_refused = 1'b1;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = ring_add(head, occ);
                back_next = cmd.value;
                if (occ == '0) begin
                  front_next = cmd.value;
                end
                occ_next = occ + CNT_W'(1);
              end
            end
            MODE_REMOVE_FRONT: begin
              if (occ > CNT_W'(1)) begin
                // The new front must come from memory; the back is unchanged.
                head_next  = ring_add(head, CNT_W'(1));
                occ_next   = occ - CNT_W'(1);
                ram_re     = 1'b1;
                ram_raddr  = head_next;
                state_next = ST_REFILL;
              end else begin
                emit = 1'b1;
                if (occ == CNT_W'(1)) begin
                  head_next = ring_add(head, CNT_W'(1));
                  occ_next  = '0;
                end
              end
            end
            MODE_SEARCH: begin
              if (occ == '0) begin
                emit = 1'b1;
              end else begin
                ram_re     = 1'b1;
                ram_raddr  = head;
                idx_next   = '0;
                state_next = ST_SEARCH;
              end
            end
            MODE_CLEAR: begin
              emit      = 1'b1;
              occ_next  = '0;
              head_next = '0;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end

      ST_REFILL: begin
        front_next = ram_rdata;
        emit       = 1'b1;
        state_next = ST_IDLE;
      end

      ST_SEARCH: begin
        // The read data belongs to entry idx; the next read is issued in the
        // same cycle so the walk covers one entry per cycle.
        if (ram_rdata == key) begin
          emit       = 1'b1;
          res_found  = 1'b1;
          state_next = ST_IDLE;
        end else if (CNT_W'(idx) == occ - CNT_W'(1)) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ring_add(head, CNT_W'(idx) + CNT_W'(1));
          idx_next  = idx + AW'(1);
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // The fill level never passes the capacity.
  assert property (@(posedge clk) disable iff (rst) occ <= CNT_W'(DEPTH))
    else $error("occupancy beyond capacity");

  // A refused insert is reported only by a full store.
  assert property (@(posedge clk) disable iff (rst)
    done && result.refused |-> result.count == CNT_W'(DEPTH))
    else $error("refusal reported while not full");

  // An empty store reports zero at both ends.
  assert property (@(posedge clk) disable iff (rst)
    done && (result.count == '0) |-> (result.front_value == '0) && (result.back_value == '0))
    else $error("empty store reported a nonzero end value");

  // A remove leaves ST_REFILL by issuing its result, with busy already low.
  assert property (@(posedge clk) disable iff (rst) state == ST_REFILL |=> done && !busy)
    else $error("remove did not complete after its front read");

endmodule

`default_nettype wire

// File: sim/bounded_deque_with_search_tb.sv
`timescale 1ns / 1ps

module bounded_deque_with_search_tb
  import bdq_pkg::*;
();

  // Mode codes that the block does not use. They must act as no-ops.
  localparam logic [2:0] MODE_NOP_5 = 3'd5;
  localparam logic [2:0] MODE_NOP_6 = 3'd6;
  localparam logic [2:0] MODE_NOP_7 = 3'd7;

  // Run limit in clock cycles. The slowest correct run is a full-store
  // search per item plus the longest sender gap, over roughly 1530
  // items. This limit leaves a wide margin above that.
  localparam int CYCLE_LIMIT = 400000;

  // Leanings of the random phases. They push the store toward full, toward
  // empty, or leave it wandering around the middle.
  typedef enum int {
    LEAN_FILL,
    LEAN_DRAIN,
    LEAN_MIXED
  } lean_t;

  // Shadow copy of the deque. Each accepted item is applied to the copy, and
  // the result that the item should produce is queued. Results from the
  // block are then compared in order against that queue.
  class deque_shadow;
    logic signed [DATA_W-1:0] slots [DEPTH];
    int head;
    int occ;
    int errors;
    result_t awaited[$];

    function new();
      head   = 0;
      occ    = 0;
      errors = 0;
      foreach (slots[k]) slots[k] = '0;
    endfunction

    // Entry k positions behind the front. It only serves to pick search
    // values that are likely to hit.
    function logic signed [DATA_W-1:0] stored_value(int k);
      return slots[(head + k) % DEPTH];
    endfunction

    function void note_cmd(cmd_t c);
      result_t r;
      r = '0;
      case (c.mode)
        MODE_INSERT_FRONT: begin
          if (occ >= DEPTH) begin
            r.refused = 1'b1;
          end else begin
            head = (head + DEPTH - 1) % DEPTH;
            slots[head] = c.value;
            occ++;
          end
        end
        MODE_INSERT_BACK: begin
          if (occ >= DEPTH) begin
            r.refused = 1'b1;
          end else begin
            slots[(head + occ) % DEPTH] = c.value;
            occ++;
          end
        end
        MODE_REMOVE_FRONT: begin
          if (occ != 0) begin
            head = (head + 1) % DEPTH;
            occ--;
          end
        end
        MODE_SEARCH: begin
          for (int i = 0; i < occ; i++) begin
            if (slots[(head + i) % DEPTH] == c.value) r.found = 1'b1;
          end
        end
        MODE_CLEAR: begin
          occ  = 0;
          head = 0;
        end
        default: begin
        end
      endcase
      if (occ != 0) begin
        r.front_value = slots[head];
        r.back_value  = slots[(head + occ - 1) % DEPTH];
      end
      r.count = CNT_W'(occ);
      awaited.insert(awaited.size(), r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (awaited.size() == 0) begin
        $error("result strobed with no item outstanding");
        errors++;
        return;
      end
      want = awaited[0];
      awaited.delete(0);
      if (got.found !== want.found) begin
        $error("found: expected %0d, got %0d", want.found, got.found);
        errors++;
      end
      if (got.front_value !== want.front_value) begin
        $error("front_value: expected %0d, got %0d", want.front_value, got.front_value);
        errors++;
      end
      if (got.back_value !== want.back_value) begin
        $error("back_value: expected %0d, got %0d", want.back_value, got.back_value);
        errors++;
      end
      if (got.count !== want.count) begin
        $error("count: expected %0d, got %0d", want.count, got.count);
        errors++;
      end
      if (got.refused !== want.refused) begin
        $error("refused: expected %0d, got %0d", want.refused, got.refused);
        errors++;
      end
    endfunction
  endclass

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  cmd_t    cmd = '0;
  logic    busy;
  logic    done;
  result_t result;

  deque_shadow shadow = new();
  int cycles = 0;
  int burst_left = 1;

  bounded_deque_with_search uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog. A hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Monitor. Both the result strobe and the item handshake are sampled at the
  // rising edge, so the values seen are the ones that were settled before the
  // edge. A result is checked before a new item is noted. Since prediction
  // runs in acceptance order, the order within one edge does not matter.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) shadow.check_result(result);
      if (start && !busy) shadow.note_cmd(cmd);
    end
  end

  // Values that hit the edges of the 32-bit range, plus a small pool that
  // makes duplicates common. The remaining values are fully random.
  function automatic logic signed [DATA_W-1:0] rand_value();
    int roll;
    roll = $urandom_range(0, 9);
    case (roll)
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return -1;
      4, 5: return $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_mode(lean_t lean);
    int roll;
    int ins_lim;
    int rem_lim;
    roll = $urandom_range(0, 99);
    if (roll < 2) return MODE_CLEAR;
    if (roll < 5) return 3'($urandom_range(MODE_NOP_5, MODE_NOP_7));
    case (lean)
      LEAN_FILL: begin
        ins_lim = 75;
        rem_lim = 85;
      end
      LEAN_DRAIN: begin
        ins_lim = 25;
        rem_lim = 80;
      end
      default: begin
        ins_lim = 45;
        rem_lim = 75;
      end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < ins_lim) return $urandom_range(0, 1) ? MODE_INSERT_BACK : MODE_INSERT_FRONT;
    if (roll < rem_lim) return MODE_REMOVE_FRONT;
    return MODE_SEARCH;
  endfunction

  // Present one item and hold it until the block takes it. Items go out in
  // bursts. When a burst runs out, start drops for a random gap, and some
  // gaps are zero so that long back-to-back stretches also occur. When there
  // is no gap, start stays high into the next item, so it gets only one
  // nonblocking write per edge.
  task automatic send_cmd(input logic [2:0] mode, input logic signed [DATA_W-1:0] value);
    cmd_t c;
    int gap;
    c.mode  = mode;
    c.value = value;
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    lean_t lean;
    int phase_left;
    logic [2:0] m;
    logic signed [DATA_W-1:0] v;

    lean = LEAN_MIXED;
    phase_left = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part. It starts on the empty store: removing and searching
    // there must do nothing, and unused codes and clearing must change
    // nothing either.
    send_cmd(MODE_REMOVE_FRONT, '0);
    send_cmd(MODE_SEARCH, '0);
    send_cmd(MODE_NOP_5, -1);
    send_cmd(MODE_NOP_7, 32'sh7fff_ffff);
    send_cmd(MODE_CLEAR, '0);

    // Fill the store from both ends. The range extremes go in first.
    for (int k = 0; k < DEPTH; k++) begin
      case (k)
        0: v = 32'sh7fff_ffff;
        1: v = 32'sh8000_0000;
        2: v = '0;
        3: v = -1;
        default: v = $urandom;
      endcase
      send_cmd(k[0] ? MODE_INSERT_BACK : MODE_INSERT_FRONT, v);
    end

    // Inserts at either end of a full store must be refused. After that
    // come a search hit on a value deep inside, a likely miss, a removal
    // from a full store, and a clear.
    send_cmd(MODE_INSERT_FRONT, 32'sd5);
    send_cmd(MODE_INSERT_BACK, 32'sd6);
    send_cmd(MODE_SEARCH, 32'sh8000_0000);
    send_cmd(MODE_SEARCH, 32'sd1);
    send_cmd(MODE_REMOVE_FRONT, '0);
    send_cmd(MODE_CLEAR, '0);

    // Random part. Phases lean toward filling or draining, so the full and
    // empty corners are hit again and again. Most searches look for a value
    // that is currently stored, so matches are frequent.
    for (int n = 0; n < 1500; n++) begin
      if (phase_left == 0) begin
        lean = lean_t'($urandom_range(0, 2));
        phase_left = $urandom_range(10, 60);
      end
      phase_left--;
      m = pick_mode(lean);
      if (m == MODE_SEARCH && shadow.occ > 0 && $urandom_range(0, 99) < 60) begin
        v = shadow.stored_value($urandom_range(0, shadow.occ - 1));
      end else begin
        v = rand_value();
      end
      send_cmd(m, v);
    end

    if (start) start <= 1'b0;

    // Drain the outstanding result, then allow time for a stray strobe.
    while (shadow.awaited.size() != 0) @(posedge clk);
    repeat (2 * DEPTH + 4) @(posedge clk);

    if (shadow.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
